[rtl/core/smeu_pkg.sv]
// smeu_pkg: shared types and constants for the stack machine execute unit
// holds stack and local file sizes, opcode and status codes, beat structs
// no dependencies
package smeu_pkg;

    localparam int DATA_DEPTH   = 64;
    localparam int CALL_DEPTH   = 32;
    localparam int NUM_LOCALS   = 64;
    localparam int PROGRAM_SIZE = 1024;

    localparam int WORD_W   = 32;
    localparam int PC_W     = $clog2(PROGRAM_SIZE);
    localparam int DD_W     = $clog2(DATA_DEPTH + 1);
    localparam int DATA_AW  = $clog2(DATA_DEPTH);
    localparam int CD_W     = $clog2(CALL_DEPTH + 1);
    localparam int CALL_AW  = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
    localparam int LOC_AW   = (NUM_LOCALS > 1) ? $clog2(NUM_LOCALS) : 1;
    localparam int VI_W     = 6;
    localparam int CMD_W    = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_NOP      = 5'd0,
        CMD_PUSH_IMM = 5'd1,
        CMD_LOAD     = 5'd2,
        CMD_STORE    = 5'd3,
        CMD_ADD      = 5'd4,
        CMD_SUB      = 5'd5,
        CMD_MUL      = 5'd6,
        CMD_NOT      = 5'd7,
        CMD_AND      = 5'd8,
        CMD_OR       = 5'd9,
        CMD_EQ       = 5'd10,
        CMD_GT       = 5'd11,
        CMD_LT       = 5'd12,
        CMD_DUP      = 5'd13,
        CMD_PRINT    = 5'd14,
        CMD_NEW      = 5'd15,
        CMD_GOTO     = 5'd16,
        CMD_IFFALSE  = 5'd17,
        CMD_INVOKE   = 5'd18,
        CMD_RETURN   = 5'd19,
        CMD_EXIT     = 5'd20
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_UNDER      = 3'd1,
        ST_OVER       = 3'd2,
        ST_UNASSIGNED = 3'd3,
        ST_CALL_UNDER = 3'd4,
        ST_CALL_OVER  = 3'd5,
        ST_HALTED     = 3'd6
    } status_t;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [WORD_W-1:0] immediate;
        logic [VI_W-1:0]          var_index;
        logic [PC_W-1:0]          target_pc;
        logic [PC_W-1:0]          current_pc;
    } item_t;

    typedef struct packed {
        logic [PC_W-1:0]          next_pc;
        logic                     print_valid;
        logic signed [WORD_W-1:0] print_value;
        logic                     halt;
        status_t                  status;
    } result_t;

endpackage

[rtl/core/stack_machine_execute_unit_core.sv]
// stack_machine_execute_unit_core: executes one stack machine instruction per beat
// depends on smeu_pkg for sizes, opcode and status codes and the beat structs
//
// usage
//   input channel: an instruction beat on item is taken at a rising edge where
//   start is high and busy is low; busy stays low, so a beat can enter every cycle
//   output channel: each instruction gives one result beat on result, marked by
//   a one-cycle done strobe; the receiver cannot stall it
//   path: the accepted beat goes through the local file read register, then
//   through execute into the result register
//   throughput: one instruction per cycle
//   the top two data stack entries and the next one below live in registers;
//   deeper entries sit in a memory whose registered read is steered by the
//   next stack depth, so pops never wait
//   reset: the data stack depth, call depth, local assigned bits and the halted flag
//   clear at once; stack and local contents are left as they are
module stack_machine_execute_unit_core
    import smeu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    done,
    output result_t result
);

    logic [WORD_W-1:0] data_mem [DATA_DEPTH];
    logic [WORD_W-1:0] loc_mem  [NUM_LOCALS];
    logic [PC_W-1:0]   ret_stack_reg [CALL_DEPTH];

    logic              ex_valid_reg;
    item_t             ex_item_reg;
    logic [WORD_W-1:0] loc_rd_reg;

    logic [WORD_W-1:0] tos_reg, tos_next;
    logic [WORD_W-1:0] nos_reg, nos_next;
    logic [WORD_W-1:0] third_reg;
    logic [DD_W-1:0]   dd_reg, dd_next;
    logic [CD_W-1:0]   rd_reg, rd_next;
    logic              halted_reg, halted_next;
    logic [NUM_LOCALS-1:0] loc_valid_reg;

    logic              done_reg;
    result_t           result_reg, result_next;

    logic               data_we;
    logic [DATA_AW-1:0] data_waddr;
    logic [DATA_AW-1:0] third_raddr;
    logic               ret_we;
    logic               loc_we;
    logic [LOC_AW-1:0]  loc_waddr;
    logic [LOC_AW-1:0]  loc_raddr;
    logic [WORD_W-1:0]  binop_val;
    logic               vi_ok;
    logic               is_full;
    logic               is_empty;
    logic [PC_W-1:0]    ret_pc;
    logic [PC_W-1:0]    pc_inc;

    assign busy = 1'b0;
    assign done = done_reg;
    assign result = result_reg;

    // input register and local file read
    assign loc_raddr = LOC_AW'(item.var_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg <= 1'b0;
        end
        else
        begin
            ex_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        ex_item_reg <= item;
        if (loc_we)
        begin
            loc_mem[loc_waddr] <= tos_reg;
        end
        if (loc_we && (loc_waddr == loc_raddr))
        begin
            loc_rd_reg <= tos_reg;
        end
        else
        begin
            loc_rd_reg <= loc_mem[loc_raddr];
        end
    end

    // execute
    assign data_waddr  = DATA_AW'(dd_reg - DD_W'(2));
    assign third_raddr = DATA_AW'(dd_next - DD_W'(3));
    assign loc_waddr   = LOC_AW'(ex_item_reg.var_index);
    assign vi_ok       = ({1'b0, ex_item_reg.var_index} < (VI_W + 1)'(NUM_LOCALS));
    assign is_full     = (dd_reg >= DD_W'(DATA_DEPTH));
    assign is_empty    = (dd_reg == '0);
    assign ret_pc      = ret_stack_reg[CALL_AW'(rd_reg - CD_W'(1))];
    assign pc_inc      = ex_item_reg.current_pc + PC_W'(1);

    always_comb
    begin
        unique case (ex_item_reg.cmd)
            CMD_ADD: binop_val = nos_reg + tos_reg;
            CMD_SUB: binop_val = nos_reg - tos_reg;
            CMD_MUL: binop_val = WORD_W'(nos_reg * tos_reg);
            CMD_AND: binop_val = WORD_W'((nos_reg != '0) && (tos_reg != '0));
            CMD_OR:  binop_val = WORD_W'((nos_reg != '0) || (tos_reg != '0));
            CMD_EQ:  binop_val = WORD_W'(nos_reg == tos_reg);
            CMD_GT:  binop_val = WORD_W'($signed(nos_reg) > $signed(tos_reg));
            default: binop_val = WORD_W'($signed(nos_reg) < $signed(tos_reg));
        endcase
    end

    always_comb
    begin
        result_next.next_pc     = pc_inc;
        result_next.print_valid = 1'b0;
        result_next.print_value = '0;
        result_next.status      = ST_OK;
        tos_next    = tos_reg;
        nos_next    = nos_reg;
        dd_next     = dd_reg;
        rd_next     = rd_reg;
        halted_next = halted_reg;
        data_we     = 1'b0;
        ret_we      = 1'b0;
        loc_we      = 1'b0;

        if (ex_valid_reg)
        begin
            if (halted_reg)
            begin
                result_next.next_pc = ex_item_reg.current_pc;
                result_next.status  = ST_HALTED;
            end
            else
            begin
                unique case (ex_item_reg.cmd)
                    CMD_PUSH_IMM, CMD_NEW, CMD_DUP, CMD_LOAD:
                    begin
                        if (is_full)
                        begin
                            result_next.status = ST_OVER;
                        end
                        else if ((ex_item_reg.cmd == CMD_DUP) && is_empty)
                        begin
                            result_next.status = ST_UNDER;
                        end
                        else if ((ex_item_reg.cmd == CMD_LOAD)
                                 && !(vi_ok && loc_valid_reg[loc_waddr]))
                        begin
                            result_next.status = ST_UNASSIGNED;
                        end
                        else
                        begin
                            data_we  = (dd_reg >= DD_W'(2));
                            nos_next = tos_reg;
                            dd_next  = dd_reg + DD_W'(1);
                            unique case (ex_item_reg.cmd)
                                CMD_PUSH_IMM: tos_next = ex_item_reg.immediate;
                                CMD_NEW:      tos_next = WORD_W'(1);
                                CMD_DUP:      tos_next = tos_reg;
                                default:      tos_next = loc_rd_reg;
                            endcase
                        end
                    end
                    CMD_STORE, CMD_PRINT, CMD_IFFALSE:
                    begin
                        if (is_empty)
                        begin
                            result_next.status = ST_UNDER;
                        end
                        else
                        begin
                            tos_next = nos_reg;
                            nos_next = third_reg;
                            dd_next  = dd_reg - DD_W'(1);
                            if (ex_item_reg.cmd == CMD_STORE)
                            begin
                                loc_we = vi_ok;
                            end
                            else if (ex_item_reg.cmd == CMD_PRINT)
                            begin
                                result_next.print_valid = 1'b1;
                                result_next.print_value = tos_reg;
                            end
                            else if (tos_reg == '0)
                            begin
                                result_next.next_pc = ex_item_reg.target_pc;
                            end
                        end
                    end
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_AND, CMD_OR, CMD_EQ, CMD_GT, CMD_LT:
                    begin
                        if (dd_reg < DD_W'(2))
                        begin
                            result_next.status = ST_UNDER;
                        end
                        else
                        begin
                            tos_next = binop_val;
                            nos_next = third_reg;
                            dd_next  = dd_reg - DD_W'(1);
                        end
                    end
                    CMD_NOT:
                    begin
                        if (is_empty)
                        begin
                            result_next.status = ST_UNDER;
                        end
                        else
                        begin
                            tos_next = WORD_W'(tos_reg == '0);
                        end
                    end
                    CMD_GOTO:
                    begin
                        result_next.next_pc = ex_item_reg.target_pc;
                    end
                    CMD_INVOKE:
                    begin
                        if (rd_reg >= CD_W'(CALL_DEPTH))
                        begin
                            result_next.status = ST_CALL_OVER;
                        end
                        else
                        begin
                            ret_we  = 1'b1;
                            rd_next = rd_reg + CD_W'(1);
                            result_next.next_pc = ex_item_reg.target_pc;
                        end
                    end
                    CMD_RETURN:
                    begin
                        if (is_empty)
                        begin
                            result_next.status = ST_UNDER;
                        end
                        else if (rd_reg == '0)
                        begin
                            result_next.status = ST_CALL_UNDER;
                        end
                        else
                        begin
                            rd_next = rd_reg - CD_W'(1);
                            result_next.next_pc = ret_pc + PC_W'(1);
                        end
                    end
                    CMD_EXIT:
                    begin
                        halted_next = 1'b1;
                        result_next.next_pc = ex_item_reg.current_pc;
                        result_next.status  = ST_HALTED;
                    end
                    default:
                    begin
                        result_next.status = ST_OK;
                    end
                endcase
            end
        end
        result_next.halt = halted_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dd_reg        <= '0;
            rd_reg        <= '0;
            halted_reg    <= 1'b0;
            loc_valid_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            dd_reg     <= dd_next;
            rd_reg     <= rd_next;
            halted_reg <= halted_next;
            done_reg   <= ex_valid_reg;
            if (loc_we)
            begin
                loc_valid_reg[loc_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
        nos_reg <= nos_next;
        if (ex_valid_reg)
        begin
            result_reg <= result_next;
        end
        if (ret_we)
        begin
            ret_stack_reg[CALL_AW'(rd_reg)] <= ex_item_reg.current_pc;
        end
    end

    // deeper data stack entries, third entry prefetched by next depth
    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[data_waddr] <= nos_reg;
        end
        if (data_we && (data_waddr == third_raddr))
        begin
            third_reg <= nos_reg;
        end
        else
        begin
            third_reg <= data_mem[third_raddr];
        end
    end

endmodule

[tb/tb_top.sv]
// tb_top: self-checking bench for stack_machine_execute_unit_core
// holds a scoreboard class with its own stack machine predictor, plus the driver and monitor
// depends on smeu_pkg and the core rtl only
module tb_top
    import smeu_pkg::*;
();

    class bytecode_scoreboard;
        logic [WORD_W-1:0] operand_stack [DATA_DEPTH];
        int unsigned       stack_depth;
        logic [PC_W-1:0]   call_stack [CALL_DEPTH];
        int unsigned       call_depth;
        logic [WORD_W-1:0] local_file [NUM_LOCALS];
        bit                local_set [NUM_LOCALS];
        bit                stopped;
        result_t           pending_results [$];
        int                errors;

        function new();
            stack_depth = 0;
            call_depth  = 0;
            stopped     = 1'b0;
            errors      = 0;
            foreach (local_set[i])
                local_set[i] = 1'b0;
        endfunction

        function string describe(result_t r);
            return $sformatf(
                "next_pc=%0d print_valid=%0b print_value=%h halt=%0b status=%0d",
                r.next_pc, r.print_valid, r.print_value, r.halt, r.status);
        endfunction

        // works out the result of one accepted instruction beat
        function void note_instruction(item_t it);
            result_t           r;
            logic [WORD_W-1:0] a;
            logic [WORD_W-1:0] b;
            logic [WORD_W-1:0] v;
            r.next_pc     = it.current_pc + PC_W'(1);
            r.print_valid = 1'b0;
            r.print_value = '0;
            r.status      = ST_OK;
            if (stopped)
            begin
                r.next_pc = it.current_pc;
                r.status  = ST_HALTED;
            end
            else
            begin
                case (it.cmd)
                    CMD_PUSH_IMM, CMD_LOAD, CMD_DUP, CMD_NEW:
                    begin
                        if (stack_depth >= DATA_DEPTH)
                            r.status = ST_OVER;
                        else if (it.cmd == CMD_DUP && stack_depth == 0)
                            r.status = ST_UNDER;
                        else if (it.cmd == CMD_LOAD &&
                                 (it.var_index >= NUM_LOCALS ||
                                  !local_set[it.var_index]))
                            r.status = ST_UNASSIGNED;
                        else
                        begin
                            if (it.cmd == CMD_PUSH_IMM)
                                v = it.immediate;
                            else if (it.cmd == CMD_NEW)
                                v = 1;
                            else if (it.cmd == CMD_DUP)
                                v = operand_stack[stack_depth-1];
                            else
                                v = local_file[it.var_index];
                            operand_stack[stack_depth] = v;
                            stack_depth++;
                        end
                    end
                    CMD_STORE:
                    begin
                        if (stack_depth == 0)
                            r.status = ST_UNDER;
                        else
                        begin
                            stack_depth--;
                            if (it.var_index < NUM_LOCALS)
                            begin
                                local_file[it.var_index] = operand_stack[stack_depth];
                                local_set[it.var_index]  = 1'b1;
                            end
                        end
                    end
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_AND, CMD_OR, CMD_EQ, CMD_GT, CMD_LT:
                    begin
                        if (stack_depth < 2)
                            r.status = ST_UNDER;
                        else
                        begin
                            a = operand_stack[stack_depth-2];
                            b = operand_stack[stack_depth-1];
                            case (it.cmd)
                                CMD_ADD: v = a + b;
                                CMD_SUB: v = a - b;
                                CMD_MUL: v = a * b;
                                CMD_AND: v = (a != 0 && b != 0) ? 1 : 0;
                                CMD_OR:  v = (a != 0 || b != 0) ? 1 : 0;
                                CMD_EQ:  v = (a == b) ? 1 : 0;
                                CMD_GT:  v = ($signed(a) > $signed(b)) ? 1 : 0;
                                default: v = ($signed(a) < $signed(b)) ? 1 : 0;
                            endcase
                            operand_stack[stack_depth-2] = v;
                            stack_depth--;
                        end
                    end
                    CMD_NOT:
                    begin
                        if (stack_depth == 0)
                            r.status = ST_UNDER;
                        else
                            operand_stack[stack_depth-1] =
                                (operand_stack[stack_depth-1] == 0) ? 1 : 0;
                    end
                    CMD_PRINT:
                    begin
                        if (stack_depth == 0)
                            r.status = ST_UNDER;
                        else
                        begin
                            stack_depth--;
                            r.print_valid = 1'b1;
                            r.print_value = operand_stack[stack_depth];
                        end
                    end
                    CMD_GOTO:
                        r.next_pc = it.target_pc;
                    CMD_IFFALSE:
                    begin
                        if (stack_depth == 0)
                            r.status = ST_UNDER;
                        else
                        begin
                            stack_depth--;
                            if (operand_stack[stack_depth] == 0)
                                r.next_pc = it.target_pc;
                        end
                    end
                    CMD_INVOKE:
                    begin
                        if (call_depth >= CALL_DEPTH)
                            r.status = ST_CALL_OVER;
                        else
                        begin
                            call_stack[call_depth] = it.current_pc;
                            call_depth++;
                            r.next_pc = it.target_pc;
                        end
                    end
                    CMD_RETURN:
                    begin
                        if (stack_depth == 0)
                            r.status = ST_UNDER;
                        else if (call_depth == 0)
                            r.status = ST_CALL_UNDER;
                        else
                        begin
                            call_depth--;
                            r.next_pc = call_stack[call_depth] + PC_W'(1);
                        end
                    end
                    CMD_EXIT:
                    begin
                        stopped   = 1'b1;
                        r.next_pc = it.current_pc;
                        r.status  = ST_HALTED;
                    end
                    default:
                    begin
                    end
                endcase
            end
            r.halt = stopped;
            pending_results = {pending_results, r};
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: %s", describe(got));
                return;
            end
            want = pending_results.pop_front();
            if (got.next_pc !== want.next_pc || got.print_valid !== want.print_valid ||
                got.print_value !== want.print_value || got.halt !== want.halt ||
                got.status !== want.status)
            begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch\n  expected %s\n  actual   %s",
                             describe(want), describe(got));
            end
        endfunction
    endclass

    typedef enum {MODE_MIX, MODE_FILL, MODE_DRAIN, MODE_CALLS, MODE_RETURNS} mix_mode_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    done;
    result_t result;

    bytecode_scoreboard sb;
    bit                 quiet_run;

    stack_machine_execute_unit_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(result);
            if (start && !busy)
                sb.note_instruction(item);
        end
    end

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic issue(input item_t it);
        int gap;
        gap = quiet_run ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic issue_op(input logic [CMD_W-1:0] c, input logic [WORD_W-1:0] imm,
                            input logic [VI_W-1:0] vi, input logic [PC_W-1:0] tgt,
                            input logic [PC_W-1:0] pc);
        item_t it;
        it.cmd        = c;
        it.immediate  = imm;
        it.var_index  = vi;
        it.target_pc  = tgt;
        it.current_pc = pc;
        issue(it);
    endtask

    function automatic item_t random_instruction(input mix_mode_t m);
        item_t       it;
        int unsigned r;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0:       it.immediate = 32'h7fff_ffff;
            1:       it.immediate = 32'h8000_0000;
            2, 3, 4: it.immediate = $urandom_range(0, 2) - 1;
            default: it.immediate = $urandom;
        endcase
        it.var_index  = ($urandom_range(0, 99) < 85) ? VI_W'($urandom_range(0, 7))
                                                     : VI_W'($urandom_range(0, 63));
        it.target_pc  = PC_W'($urandom_range(0, PROGRAM_SIZE - 1));
        it.current_pc = PC_W'($urandom_range(0, PROGRAM_SIZE - 1));
        case (m)
            MODE_FILL:
                it.cmd = (r < 50) ? CMD_PUSH_IMM : (r < 65) ? CMD_NEW : (r < 78) ? CMD_DUP :
                         (r < 90) ? CMD_LOAD : CMD_STORE;
            MODE_DRAIN:
                it.cmd = (r < 20) ? CMD_PRINT : (r < 35) ? CMD_STORE : (r < 50) ? CMD_IFFALSE :
                         (r < 60) ? CMD_ADD : (r < 68) ? CMD_SUB : (r < 74) ? CMD_MUL :
                         (r < 79) ? CMD_AND : (r < 84) ? CMD_OR : (r < 88) ? CMD_EQ :
                         (r < 92) ? CMD_GT : (r < 96) ? CMD_LT : CMD_NOT;
            MODE_CALLS:
                it.cmd = (r < 60) ? CMD_INVOKE : (r < 80) ? CMD_PUSH_IMM :
                         (r < 90) ? CMD_GOTO : CMD_NEW;
            MODE_RETURNS:
                it.cmd = (r < 45) ? CMD_RETURN : (r < 75) ? CMD_PUSH_IMM : (r < 85) ? CMD_DUP :
                         (r < 92) ? CMD_IFFALSE : CMD_PRINT;
            default:
            begin
                it.cmd = CMD_W'($urandom_range(0, 31));
                if (it.cmd == CMD_EXIT)
                    it.cmd = CMD_W'($urandom_range(21, 31));
            end
        endcase
        return it;
    endfunction

    initial
    begin
        mix_mode_t mode;
        int        left;
        item_t     it;
        sb        = new();
        quiet_run = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // underflow and unassigned cases from an empty machine
        issue_op(CMD_ADD,      0, 0, 0, 10);
        issue_op(CMD_PRINT,    0, 0, 0, 11);
        issue_op(CMD_IFFALSE,  0, 0, 700, 12);
        issue_op(CMD_LOAD,     0, 5, 0, 13);
        // arithmetic wrap and signed compares, pc wrap at the top
        issue_op(CMD_PUSH_IMM, 32'h7fff_ffff, 0, 0, 1023);
        issue_op(CMD_PUSH_IMM, 1, 0, 0, 0);
        issue_op(CMD_ADD,      0, 0, 0, 1);
        issue_op(CMD_PUSH_IMM, 32'h8000_0000, 0, 0, 2);
        issue_op(CMD_EQ,       0, 0, 0, 3);
        issue_op(CMD_PUSH_IMM, 32'hffff_ffff, 0, 0, 4);
        issue_op(CMD_MUL,      0, 0, 0, 5);
        issue_op(CMD_DUP,      0, 0, 0, 6);
        issue_op(CMD_GT,       0, 0, 0, 7);
        issue_op(CMD_NEW,      0, 0, 0, 8);
        issue_op(CMD_LT,       0, 0, 0, 9);
        issue_op(CMD_PUSH_IMM, 0, 0, 0, 10);
        issue_op(CMD_OR,       0, 0, 0, 11);
        issue_op(CMD_NOT,      0, 0, 0, 12);
        issue_op(CMD_NEW,      0, 0, 0, 13);
        issue_op(CMD_AND,      0, 0, 0, 14);
        issue_op(CMD_NEW,      0, 0, 0, 15);
        issue_op(CMD_SUB,      0, 0, 0, 16);
        issue_op(CMD_STORE,    0, 63, 0, 17);
        issue_op(CMD_LOAD,     0, 63, 0, 18);
        issue_op(CMD_NOT,      0, 0, 0, 19);
        issue_op(CMD_IFFALSE,  0, 0, 512, 20);
        // calls and returns, then a goto, a nop and an unused opcode
        issue_op(CMD_NEW,      0, 0, 0, 21);
        issue_op(CMD_RETURN,   0, 0, 0, 22);
        issue_op(CMD_INVOKE,   0, 0, 100, 50);
        issue_op(CMD_RETURN,   0, 0, 0, 100);
        issue_op(CMD_PRINT,    0, 0, 0, 51);
        issue_op(CMD_GOTO,     0, 0, 300, 1023);
        issue_op(CMD_NOP,      0, 0, 0, 300);
        issue_op(5'd31,        0, 0, 0, 301);

        mode = MODE_MIX;
        left = 0;
        for (int n = 0; n < 650; n++)
        begin
            if (left == 0)
            begin
                mode      = mix_mode_t'($urandom_range(0, 4));
                quiet_run = ($urandom_range(0, 3) == 0);
                case (mode)
                    MODE_FILL, MODE_DRAIN: left = $urandom_range(70, 100);
                    MODE_CALLS:            left = $urandom_range(60, 80);
                    default:               left = $urandom_range(20, 50);
                endcase
            end
            issue(random_instruction(mode));
            left--;
        end

        // exit, then the machine must stay halted
        quiet_run = 1'b0;
        issue_op(CMD_EXIT, 0, 0, 0, PC_W'($urandom_range(0, PROGRAM_SIZE - 1)));
        repeat (8)
        begin
            it     = random_instruction(MODE_MIX);
            it.cmd = CMD_W'($urandom_range(0, 31));
            issue(it);
        end
        start <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
